@@ rtl/core/hsfd_pkg.sv @@
// Package: shared types, constants and CRC-8 step function of the frame decoder.
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Frame lengths in bytes and positions of the CRC bytes.
  localparam logic [2:0] LenLong   = 3'd6;
  localparam logic [2:0] LenShort  = 3'd3;
  localparam logic [2:0] PosCrc0   = 3'd2;
  localparam logic [2:0] PosCrc1   = 3'd5;

  // Conversion constants.
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [15:0] DivConst   = 16'hFFFF;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [13:0] HumMax     = 14'd10000;

  typedef enum logic [1:0] {
    KIND_MEAS   = 2'd0,
    KIND_SERIAL = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Completed frame handed from the byte parser to the converter.
  typedef struct packed {
    kind_e       kind;
    logic        crc_fail;
    logic [15:0] w0;
    logic [15:0] w1;
  } frame_item_t;

  // Products registered between the multiply and the divide stage.
  typedef struct packed {
    kind_e       kind;
    logic        crc_fail;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [30:0] temp_prod;
    logic [29:0] hum_prod;
  } conv_item_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsfd_if.sv @@
// Interfaces: byte input channel and result output channel.
`default_nettype none

interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       frame_start;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output frame_start, output rx_byte,
                  input ready);
  modport sink   (input valid, input mode, input frame_start, input rx_byte,
                  output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic               result_status;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [31:0]        serial_number;
  logic [15:0]        status_word;

  modport source (output valid, output frame_kind, output result_status,
                  output temperature_centi, output humidity_centi,
                  output serial_number, output status_word, input ready);
  modport sink   (input valid, input frame_kind, input result_status,
                  input temperature_centi, input humidity_centi,
                  input serial_number, input status_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hsfd_frame.sv @@
// Byte parser: frame position, running CRC-8 check, word capture, frame item register.
`default_nettype none

module hsfd_frame (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  hsfd_in_if.sink                  in_i,
  output hsfd_pkg::frame_item_t    item_o,
  output logic                     item_valid_o,
  input  wire logic                item_ready_i
);
  import hsfd_pkg::*;

  logic [2:0]  byte_idx_q, byte_idx_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  crc_q, crc_d;
  logic        fail_q, fail_d;
  logic [7:0]  word_bytes_q [4];

  frame_item_t item_q;
  logic        item_valid_q;

  logic        accept;
  kind_e       kind_eff;
  logic [2:0]  idx_eff, pos, len;
  logic [7:0]  crc_eff;
  logic        fail_eff, fail_upd, is_crc, is_last;
  logic [1:0]  wr_sel;

  assign in_i.ready = !item_valid_q || item_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (in_i.frame_start) begin
      unique case (in_i.mode)
        KIND_MEAS:   kind_eff = KIND_MEAS;
        KIND_SERIAL: kind_eff = KIND_SERIAL;
        default:     kind_eff = KIND_STATUS;
      endcase
      idx_eff  = '0;
      crc_eff  = CrcInit;
      fail_eff = 1'b0;
    end else begin
      kind_eff = kind_q;
      idx_eff  = byte_idx_q;
      crc_eff  = crc_q;
      fail_eff = fail_q;
    end

    len = (kind_eff == KIND_STATUS) ? LenShort : LenLong;
    pos = (idx_eff >= len) ? 3'd0 : idx_eff;

    is_crc   = (pos == PosCrc0) || (pos == PosCrc1);
    is_last  = (pos + 3'd1 == len);
    fail_upd = fail_eff | (is_crc && (crc_eff != in_i.rx_byte));

    // byte positions 0,1,3,4 map to word byte slots 0..3
    wr_sel = (pos > PosCrc0) ? 2'(pos - 3'd1) : pos[1:0];

    kind_d = kind_eff;
    if (is_last) begin
      byte_idx_d = '0;
      crc_d      = CrcInit;
      fail_d     = 1'b0;
    end else begin
      byte_idx_d = pos + 3'd1;
      crc_d      = is_crc ? CrcInit : crc8_update(crc_eff, in_i.rx_byte);
      fail_d     = fail_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      kind_q     <= KIND_MEAS;
      crc_q      <= CrcInit;
      fail_q     <= 1'b0;
    end else if (accept) begin
      byte_idx_q <= byte_idx_d;
      kind_q     <= kind_d;
      crc_q      <= crc_d;
      fail_q     <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_crc) begin
      word_bytes_q[wr_sel] <= in_i.rx_byte;
    end
  end

  // The last byte of a frame is always a CRC byte, so the word slots are complete.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= accept && is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_last) begin
      item_q.kind     <= kind_eff;
      item_q.crc_fail <= fail_upd;
      item_q.w0       <= {word_bytes_q[0], word_bytes_q[1]};
      item_q.w1       <= {word_bytes_q[2], word_bytes_q[3]};
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = item_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/hsfd_conv.sv @@
// Converter: scale multiply stage, divide-by-65535 stage and result register.
`default_nettype none

module hsfd_conv (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hsfd_pkg::frame_item_t item_i,
  input  wire logic                item_valid_i,
  output logic                     item_ready_o,
  hsfd_out_if.source               out_o
);
  import hsfd_pkg::*;

  conv_item_t  mul_q;
  logic        mul_valid_q;
  logic        mul_ready, out_ready;

  logic        out_valid_q;
  kind_e       kind_q;
  logic        status_q;
  logic signed [14:0] temp_q;
  logic [13:0] hum_q;
  logic [31:0] serial_q;
  logic [15:0] stat_q;

  // divide stage signals
  logic [14:0] tq;
  logic [16:0] trem;
  logic [14:0] tfloor;
  logic        tfrac;
  logic [15:0] tval;
  logic [13:0] hq;
  logic [16:0] hrem;
  logic [13:0] hfloor;
  logic [13:0] hval;

  assign out_ready    = !out_valid_q || out_o.ready;
  assign mul_ready    = !mul_valid_q || out_ready;
  assign item_ready_o = mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && item_valid_i) begin
      mul_q.kind      <= item_i.kind;
      mul_q.crc_fail  <= item_i.crc_fail;
      mul_q.w0        <= item_i.w0;
      mul_q.w1        <= item_i.w1;
      mul_q.temp_prod <= 31'(item_i.w0) * 31'(TempScale);
      mul_q.hum_prod  <= 30'(item_i.w1) * 30'(HumScale);
    end
  end

  // x / 65535 with x < 2^31: q = x >> 16, remainder = low half + q, one correction.
  always_comb begin
    tq   = mul_q.temp_prod[30:16];
    trem = 17'(mul_q.temp_prod[15:0]) + 17'(tq);
    if (trem >= 17'(DivConst)) begin
      tfloor = tq + 15'd1;
      tfrac  = (trem != 17'(DivConst));
    end else begin
      tfloor = tq;
      tfrac  = (trem != 17'd0);
    end
    // truncation toward zero: a negative result with a fraction rounds up
    tval = 16'(tfloor) - TempOffset
         + 16'((16'(tfloor) < TempOffset) && tfrac);

    hq   = mul_q.hum_prod[29:16];
    hrem = 17'(mul_q.hum_prod[15:0]) + 17'(hq);
    hfloor = (hrem >= 17'(DivConst)) ? hq + 14'd1 : hq;
    hval   = (hfloor > HumMax) ? HumMax : hfloor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mul_valid_q) begin
      kind_q   <= mul_q.kind;
      status_q <= mul_q.crc_fail;
      unique case (mul_q.kind)
        KIND_MEAS: begin
          temp_q   <= signed'(tval[14:0]);
          hum_q    <= hval;
          serial_q <= '0;
          stat_q   <= '0;
        end
        KIND_SERIAL: begin
          temp_q   <= '0;
          hum_q    <= '0;
          serial_q <= {mul_q.w0, mul_q.w1};
          stat_q   <= '0;
        end
        default: begin
          temp_q   <= '0;
          hum_q    <= '0;
          serial_q <= '0;
          stat_q   <= mul_q.w0;
        end
      endcase
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.frame_kind        = kind_q;
  assign out_o.result_status     = status_q;
  assign out_o.temperature_centi = temp_q;
  assign out_o.humidity_centi    = hum_q;
  assign out_o.serial_number     = serial_q;
  assign out_o.status_word       = stat_q;

endmodule

`default_nettype wire

@@ rtl/core/humidity_sensor_frame_decoder.sv @@
// Throughput: one byte item per cycle; input stalls only while all three stages hold results
// and the output is not taken.
// Stages: frame item register, scale multiply register, divide and result register.
// Reset (rst_ni low, asynchronous): frame position 0, measurement kind, CRC 0xFF,
// no pending results. Captured word bytes are not reset.
`default_nettype none

module humidity_sensor_frame_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsfd_in_if.sink    in_i,
  hsfd_out_if.source out_o
);
  import hsfd_pkg::*;

  frame_item_t frame_item;
  logic        frame_valid;
  logic        frame_ready;

  hsfd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (frame_item),
    .item_valid_o (frame_valid),
    .item_ready_i (frame_ready)
  );

  hsfd_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (frame_item),
    .item_valid_i (frame_valid),
    .item_ready_o (frame_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
